// ===== rtl/core/pid_controller_two_form_assert.svh =====
// ---------------------------------------------------------------------------
// pid controller two form assertion macros
// concurrent checks on the controller logic, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_TWO_FORM_ASSERT_SVH
`define PID_CONTROLLER_TWO_FORM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cond never holds outside reset
`define PID2F_ASSERT_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("%m: assertion failed");

// pre implies post in the same cycle
`define PID2F_ASSERT_IMPLY(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("%m: assertion failed");

// pre implies post in the next cycle
`define PID2F_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("%m: assertion failed");

`else

`define PID2F_ASSERT_NEVER(name, clk, rstn, cond)
`define PID2F_ASSERT_IMPLY(name, clk, rstn, pre, post)
`define PID2F_ASSERT_NEXT(name, clk, rstn, pre, post)

`endif

`endif

// ===== rtl/core/pid2f_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid2f_pkg
// shared types, constants and register map of the two form pid controller
// ---------------------------------------------------------------------------
package pid2f_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int LIMITS_ON_DEF      = 1;

    localparam int GAIN_W     = 16;
    localparam int ALPHA_W    = 16;
    localparam int FILT_FRAC  = 16;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // serial multiplier: one multiplier bit per cycle
    localparam int MPLIER_W  = ALPHA_W + 1;
    localparam int MUL_CNT_W = $clog2(MPLIER_W);

    localparam logic [MPLIER_W-1:0] FILT_ONE = MPLIER_W'(1) << FILT_FRAC;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd25600;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd2560;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd2560;
    localparam logic [ALPHA_W-1:0] ALPHA_RST  = 16'd0;

    localparam logic FORM_INC = 1'b0;
    localparam logic FORM_POS = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT     = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_DERIV_FILTER = 3'd4,
        REG_OUT_UPPER    = 3'd5,
        REG_OUT_LOWER    = 3'd6,
        REG_FORM_SELECT  = 3'd7
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SAT  = 5'b01000,
        ST_DONE = 5'b10000
    } pid2f_state_t;

endpackage

// ===== rtl/core/pid_controller_two_form.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_controller_two_form
// fixed point pid controller, incremental or positional form.
// s_ channel: one measured sample per request; m_ channel: the clamped drive
// value in m_tdata and the clamp flag in m_tuser, one result per request.
// cfg port: registers are written by cfg_wr_en, cfg_index, cfg_wdata; write
// only while no request is in flight.
// a request goes through a shared shift-add multiplier that takes one
// multiplier bit per cycle; a product takes a load step, one step per
// multiplier bit and a handoff step.
// incremental form: 3 products; positional form: 5 products. the next
// request is taken only once the previous one has left its last step.
// reset loads the register defaults and clears the error history, the held
// output, the filtered derivative and the error sum.
// a stalled result stays in the output register; the next request is taken
// and computed, and waits at its last step until the result is taken.
// ---------------------------------------------------------------------------
module pid_controller_two_form
    import pid2f_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int LIMITS_ON      = LIMITS_ON_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // measured
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_W-1:0]                    m_tdata,   // drive
    output logic                                m_tuser    // clamped
);

    logic signed [SAMPLE_WIDTH-1:0] setpoint_reg;
    logic [GAIN_W-1:0]              gain_p_reg;
    logic [GAIN_W-1:0]              gain_i_reg;
    logic [GAIN_W-1:0]              gain_d_reg;
    logic [ALPHA_W-1:0]             deriv_filter_reg;
    logic signed [OUT_W-1:0]        out_upper_reg;
    logic signed [OUT_W-1:0]        out_lower_reg;
    logic                           form_select_reg;
    logic signed [OUT_W-1:0]        drive;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg     <= '0;
            gain_p_reg       <= GAIN_P_RST;
            gain_i_reg       <= GAIN_I_RST;
            gain_d_reg       <= GAIN_D_RST;
            deriv_filter_reg <= ALPHA_RST;
            out_upper_reg    <= OUT_MAX;
            out_lower_reg    <= OUT_MIN;
            form_select_reg  <= FORM_INC;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SETPOINT:     setpoint_reg     <= cfg_wdata[SAMPLE_WIDTH-1:0];
                REG_GAIN_P:       gain_p_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:       gain_i_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:       gain_d_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_FILTER: deriv_filter_reg <= cfg_wdata[ALPHA_W-1:0];
                REG_OUT_UPPER:    out_upper_reg    <= cfg_wdata[OUT_W-1:0];
                REG_OUT_LOWER:    out_lower_reg    <= cfg_wdata[OUT_W-1:0];
                REG_FORM_SELECT:  form_select_reg  <= cfg_wdata[0];
                default: begin
                    form_select_reg <= form_select_reg;
                end
            endcase
        end
    end

    pid2f_core #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .LIMITS_ON      (LIMITS_ON)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .setpoint     (setpoint_reg),
        .gain_p       (gain_p_reg),
        .gain_i       (gain_i_reg),
        .gain_d       (gain_d_reg),
        .deriv_filter (deriv_filter_reg),
        .out_upper    (out_upper_reg),
        .out_lower    (out_lower_reg),
        .form_select  (form_select_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_measured  (s_tdata[SAMPLE_WIDTH-1:0]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_drive    (drive),
        .out_clamped  (m_tuser)
    );

    assign m_tdata = drive;

endmodule

// ===== rtl/core/pid2f_mul.sv =====
`timescale 1ns / 1ps
`include "pid_controller_two_form_assert.svh"
// ---------------------------------------------------------------------------
// pid2f_mul
// shift and add multiply accumulate, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module pid2f_mul
    import pid2f_pkg::*;
#(
    parameter int ACC_WIDTH = SAMPLE_WIDTH_DEF + 36
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [ACC_WIDTH-1:0] acc_init,
    input  logic signed [ACC_WIDTH-1:0] mcand_init,
    input  logic [MPLIER_W-1:0]         mplier_init,
    output logic                        busy,
    output logic signed [ACC_WIDTH-1:0] acc
);

    logic                        busy_reg;
    logic [MUL_CNT_W-1:0]        cnt_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] mcand_reg;
    logic [MPLIER_W-1:0]         mplier_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= MUL_CNT_W'(MPLIER_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= acc_init;
            mcand_reg  <= mcand_init;
            mplier_reg <= mplier_init;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

    `PID2F_ASSERT_NEVER(a_no_restart, aclk, aresetn, start && busy_reg)
    `PID2F_ASSERT_NEXT(a_last_bit_ends, aclk, aresetn, busy_reg && cnt_reg == '0 && !start, !busy_reg)
    `PID2F_ASSERT_IMPLY(a_mplier_drained, aclk, aresetn, $fell(busy_reg), mplier_reg == '0)

endmodule

// ===== rtl/core/pid2f_core.sv =====
`timescale 1ns / 1ps
`include "pid_controller_two_form_assert.svh"
// ---------------------------------------------------------------------------
// pid2f_core
// term sequencer, controller history, saturation, clamp and output register
// ---------------------------------------------------------------------------
module pid2f_core
    import pid2f_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int LIMITS_ON      = LIMITS_ON_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
    input  logic [GAIN_W-1:0]              gain_p,
    input  logic [GAIN_W-1:0]              gain_i,
    input  logic [GAIN_W-1:0]              gain_d,
    input  logic [ALPHA_W-1:0]             deriv_filter,
    input  logic signed [OUT_W-1:0]        out_upper,
    input  logic signed [OUT_W-1:0]        out_lower,
    input  logic                           form_select,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_measured,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [OUT_W-1:0]        out_drive,
    output logic                           out_clamped
);

    localparam int EW     = SAMPLE_WIDTH + 1;
    localparam int AW     = (SAMPLE_WIDTH + 36 > OUT_W + GAIN_W + 4) ? SAMPLE_WIDTH + 36
                                                                      : OUT_W + GAIN_W + 4;
    localparam int TERM_W = 3;

    // incremental form terms
    localparam logic [TERM_W-1:0] INC_T_PROP  = 3'd0;
    localparam logic [TERM_W-1:0] INC_T_INTEG = 3'd1;
    localparam logic [TERM_W-1:0] INC_T_DERIV = 3'd2;
    // positional form terms
    localparam logic [TERM_W-1:0] POS_T_DERIV  = 3'd0;
    localparam logic [TERM_W-1:0] POS_T_WEIGHT = 3'd1;
    localparam logic [TERM_W-1:0] POS_T_FILT   = 3'd2;
    localparam logic [TERM_W-1:0] POS_T_PROP   = 3'd3;
    localparam logic [TERM_W-1:0] POS_T_INTEG  = 3'd4;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [AW-1:0] v);
        logic [AW-OUT_W:0] hi;
        hi = v[AW-1:OUT_W-1];
        if (hi == '0 || hi == '1) begin
            sat_out = v[OUT_W-1:0];
        end else if (v[AW-1]) begin
            sat_out = OUT_MIN;
        end else begin
            sat_out = OUT_MAX;
        end
    endfunction

    pid2f_state_t state_reg, state_next;
    logic [TERM_W-1:0] term_reg, term_next;

    logic signed [EW-1:0]    err_reg;
    logic signed [EW-1:0]    prev_err_reg;
    logic signed [EW-1:0]    prev2_err_reg;
    logic signed [OUT_W-1:0] held_reg;
    logic signed [OUT_W-1:0] ud_prev_reg;
    logic signed [OUT_W-1:0] esum_reg;
    logic signed [OUT_W-1:0] ud_reg;
    logic signed [OUT_W-1:0] res_reg;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] drive_reg;
    logic                    clamped_reg;

    logic signed [EW-1:0]    err_in;
    logic signed [AW-1:0]    err_w;
    logic signed [AW-1:0]    d1_w;
    logic signed [AW-1:0]    d2_w;
    logic signed [AW-1:0]    t1_w;
    logic signed [OUT_W-1:0] ud_sat;
    logic signed [AW-1:0]    ud_load;
    logic signed [AW-1:0]    held_load;
    logic signed [AW-1:0]    esum_sum;
    logic [MPLIER_W-1:0]     weight;

    logic                    mul_start;
    logic                    mul_busy;
    logic signed [AW-1:0]    acc;
    logic signed [AW-1:0]    acc_init;
    logic signed [AW-1:0]    mcand_init;
    logic [MPLIER_W-1:0]     mplier_init;

    logic                    last_term;
    logic                    term_ok;
    logic                    out_free;
    logic signed [OUT_W-1:0] clamp_val;
    logic                    clamp_flag;

    assign err_in    = EW'(setpoint) - EW'(in_measured);
    assign err_w     = AW'(err_reg);
    assign d1_w      = err_w - AW'(prev_err_reg);
    assign d2_w      = err_w - (AW'(prev_err_reg) <<< 1) + AW'(prev2_err_reg);
    assign t1_w      = (acc >>> (FILT_FRAC + GAIN_FRAC_BITS)) <<< FILT_FRAC;
    assign ud_sat    = sat_out(acc >>> FILT_FRAC);
    assign ud_load   = AW'(ud_sat) <<< GAIN_FRAC_BITS;
    assign held_load = AW'(held_reg) <<< GAIN_FRAC_BITS;
    assign esum_sum  = AW'(esum_reg) + err_w;
    assign weight    = FILT_ONE - MPLIER_W'(deriv_filter);

    assign last_term = (form_select == FORM_POS) ? (term_reg == POS_T_INTEG)
                                                 : (term_reg == INC_T_DERIV);
    assign term_ok   = (form_select == FORM_POS) ? (term_reg <= POS_T_INTEG)
                                                 : (term_reg <= INC_T_DERIV);
    assign out_free  = !out_valid_reg || out_ready;
    assign mul_start = (state_reg == ST_LOAD);

    // operands of the current term
    always_comb begin
        acc_init    = acc;
        mcand_init  = '0;
        mplier_init = '0;
        if (form_select == FORM_POS) begin
            unique case (term_reg)
                POS_T_DERIV: begin
                    acc_init    = '0;
                    mcand_init  = d1_w;
                    mplier_init = MPLIER_W'(gain_d);
                end
                POS_T_WEIGHT: begin
                    acc_init    = '0;
                    mcand_init  = acc;
                    mplier_init = weight;
                end
                POS_T_FILT: begin
                    acc_init    = t1_w;
                    mcand_init  = AW'(ud_prev_reg);
                    mplier_init = MPLIER_W'(deriv_filter);
                end
                POS_T_PROP: begin
                    acc_init    = ud_load;
                    mcand_init  = err_w;
                    mplier_init = MPLIER_W'(gain_p);
                end
                POS_T_INTEG: begin
                    mcand_init  = AW'(esum_reg);
                    mplier_init = MPLIER_W'(gain_i);
                end
                default: begin
                    acc_init = acc;
                end
            endcase
        end else begin
            unique case (term_reg)
                INC_T_PROP: begin
                    acc_init    = held_load;
                    mcand_init  = d1_w;
                    mplier_init = MPLIER_W'(gain_p);
                end
                INC_T_INTEG: begin
                    mcand_init  = err_w;
                    mplier_init = MPLIER_W'(gain_i);
                end
                INC_T_DERIV: begin
                    mcand_init  = d2_w;
                    mplier_init = MPLIER_W'(gain_d);
                end
                default: begin
                    acc_init = acc;
                end
            endcase
        end
    end

    pid2f_mul #(
        .ACC_WIDTH (AW)
    ) u_mul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (mul_start),
        .acc_init    (acc_init),
        .mcand_init  (mcand_init),
        .mplier_init (mplier_init),
        .busy        (mul_busy),
        .acc         (acc)
    );

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_LOAD;
                    term_next  = '0;
                end
            end
            ST_LOAD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (!mul_busy) begin
                    if (last_term) begin
                        state_next = ST_SAT;
                    end else begin
                        term_next  = term_reg + TERM_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_SAT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // upper limit first, then lower
    always_comb begin
        clamp_val  = res_reg;
        clamp_flag = 1'b0;
        if (LIMITS_ON != 0) begin
            if (res_reg > out_upper) begin
                clamp_val  = out_upper;
                clamp_flag = 1'b1;
            end
            if (clamp_val < out_lower) begin
                clamp_val  = out_lower;
                clamp_flag = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            term_reg      <= '0;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            prev2_err_reg <= '0;
            held_reg      <= '0;
            ud_prev_reg   <= '0;
            esum_reg      <= '0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
                held_reg      <= clamp_val;
                prev_err_reg  <= err_reg;
                if (form_select == FORM_POS) begin
                    ud_prev_reg <= ud_reg;
                    esum_reg    <= sat_out(esum_sum);
                end else begin
                    prev2_err_reg <= prev_err_reg;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_valid) begin
            err_reg <= err_in;
        end
        if (state_reg == ST_LOAD && form_select == FORM_POS && term_reg == POS_T_PROP) begin
            ud_reg <= ud_sat;
        end
        if (state_reg == ST_SAT) begin
            res_reg <= sat_out(acc >>> GAIN_FRAC_BITS);
        end
        if (state_reg == ST_DONE && out_free) begin
            drive_reg   <= clamp_val;
            clamped_reg <= clamp_flag;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_drive   = drive_reg;
    assign out_clamped = clamped_reg;

    `PID2F_ASSERT_IMPLY(a_busy_in_mul, aclk, aresetn, mul_busy, state_reg == ST_MUL)
    `PID2F_ASSERT_IMPLY(a_term_range, aclk, aresetn, state_reg != ST_IDLE, term_ok)

endmodule
